### sv/plt_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and functions of the palette unit.
// No dependencies; every other file of the block uses it.
package plt_pkg;

  // Field widths of the channel payloads
  localparam int IDX_W   = 8;
  localparam int COLOR_W = 16;
  localparam int DIST_W  = 13;  // 2*31^2 + 63^2 + 2*31^2 = 7813 fits

  // Default palette depth
  localparam int PALETTE_ENTRIES = 256;

  // Reset contents of the palette
  localparam logic [COLOR_W-1:0] GRAY_STEP = 16'h0821;
  localparam logic [COLOR_W-1:0] RESET_RED = 16'hF800;
  localparam logic [COLOR_W-1:0] RESET_WHITE = 16'hFFFF;
  localparam logic [IDX_W-1:0]   RED_ENTRY = 8'd1;
  localparam logic [IDX_W-1:0]   WHITE_ENTRY = 8'd2;

  // Operation codes of an input beat
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_SEARCH = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_SCAN = 3'b100
  } state_e;

  // Palette memory request
  typedef struct packed {
    logic               wr_en;
    logic               rd_en;
    logic [IDX_W-1:0]   addr;
    logic [COLOR_W-1:0] wdata;
  } mem_req_t;

  // Color an entry holds before it is first written: gray ramp with red and white
  function automatic logic [COLOR_W-1:0] reset_color(input logic [IDX_W-1:0] idx);
    logic [COLOR_W-1:0] ramp;
    ramp = COLOR_W'({{(COLOR_W-IDX_W){1'b0}}, idx} * GRAY_STEP);
    if (idx == RED_ENTRY) begin
      return RESET_RED;
    end else if (idx == WHITE_ENTRY) begin
      return RESET_WHITE;
    end else begin
      return ramp;
    end
  endfunction

endpackage

### sv/plt_if.sv
`timescale 1ns / 1ps
// Valid/ready channels of the palette unit: command beats in, result beats out.
// Depends on plt_pkg for the field widths.
interface plt_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  operation;
  logic [plt_pkg::IDX_W-1:0]   entry_index;
  logic [plt_pkg::COLOR_W-1:0] rgb_color;

  modport source (output valid, output operation, output entry_index, output rgb_color,
                  input ready);
  modport sink   (input valid, input operation, input entry_index, input rgb_color,
                  output ready);
endinterface

interface plt_out_if;
  logic                        valid;
  logic                        ready;
  logic [plt_pkg::COLOR_W-1:0] found_color;
  logic [plt_pkg::IDX_W-1:0]   found_index;

  modport source (output valid, output found_color, output found_index, input ready);
  modport sink   (input valid, input found_color, input found_index, output ready);
endinterface

### sv/palette_lookup_nearest_color.sv
`timescale 1ns / 1ps
// Palette unit top level: sequencer, cache, result register; instantiates plt_mem, plt_dist.
// Depends on plt_pkg and the channel interfaces in plt_if.
//
//   channel | dir | fields                                   | beat
//   in_i    | in  | operation, entry_index, rgb_color        | valid & ready
//   out_o   | out | found_color, found_index                 | valid & ready
//
// Write: no result beat. Lookup: the read data is registered in plt_mem, then in the
// result register. Search that hits the cached color: result on the next cycle.
// Search that misses: one entry per cycle through the single memory read port and
// the shared distance unit; no new beat is taken meanwhile.
// Reset takes effect at once: per-entry valid bits give the reset palette, no clear pass.
// A held result beat stalls the input until the result is taken or taken in that cycle.
module palette_lookup_nearest_color #(
  parameter int PALETTE_ENTRIES = plt_pkg::PALETTE_ENTRIES
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  plt_in_if.sink    in_i,
  plt_out_if.source out_o
);

  localparam int IdxW   = plt_pkg::IDX_W;
  localparam int ColorW = plt_pkg::COLOR_W;
  localparam int DistW  = plt_pkg::DIST_W;
  localparam int AddrW  = $clog2(PALETTE_ENTRIES);
  localparam int CntW   = $clog2(PALETTE_ENTRIES + 1);
  localparam int CmpW   = IdxW + 1;
  localparam logic [CmpW-1:0]  NumEntries = CmpW'(PALETTE_ENTRIES);
  localparam logic [CntW-1:0]  CntEntries = CntW'(PALETTE_ENTRIES);
  localparam logic [AddrW-1:0] LastIdx    = AddrW'(PALETTE_ENTRIES - 1);

  plt_pkg::state_e   state_q, state_d;
  plt_pkg::mem_req_t mem_req;
  plt_pkg::op_e      op;

  logic              acc, in_range, cache_hit, out_free;
  logic [ColorW-1:0] rd_data;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              issue;
  logic              rd_vld_q;
  logic [AddrW-1:0]  rd_idx_q;
  logic [ColorW-1:0] tgt_q, tgt_d;
  logic              dv;
  logic [DistW-1:0]  dd;
  logic [AddrW-1:0]  di;
  logic              take, done;
  logic [DistW-1:0]  best_q, best_d;
  logic [AddrW-1:0]  bi_q, bi_d;
  logic              cache_vld_q, cache_vld_d;
  logic [ColorW-1:0] cache_color_q, cache_color_d;
  logic [IdxW-1:0]   cache_idx_q, cache_idx_d;
  logic              out_vld_q, out_vld_d;
  logic [ColorW-1:0] out_color_q, out_color_d;
  logic [IdxW-1:0]   out_idx_q, out_idx_d;

  // Decode the input beat
  assign op        = plt_pkg::op_e'(in_i.operation);
  assign out_free  = !out_vld_q || out_o.ready;
  assign in_i.ready = (state_q == plt_pkg::S_IDLE) && out_free;
  assign acc       = in_i.valid && in_i.ready;
  assign in_range  = {1'b0, in_i.entry_index} < NumEntries;
  assign cache_hit = cache_vld_q && (cache_color_q == in_i.rgb_color);

  // Scan address issue
  assign issue = (state_q == plt_pkg::S_SCAN) && (cnt_q < CntEntries);

  plt_mem #(
    .Entries (PALETTE_ENTRIES)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  plt_dist #(
    .AddrW (AddrW)
  ) u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (rd_vld_q),
    .pal_color_i (rd_data),
    .tgt_color_i (tgt_q),
    .idx_i       (rd_idx_q),
    .vld_o       (dv),
    .dist_o      (dd),
    .idx_o       (di)
  );

  // Keep the running minimum; the lowest index wins a tie
  assign take   = dv && ((di == '0) || (dd < best_q));
  assign done   = dv && (di == LastIdx);
  assign best_d = take ? dd : best_q;
  assign bi_d   = take ? di : bi_q;

  // Sequencer, memory requests, cache and result register
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    tgt_d         = tgt_q;
    cache_vld_d   = cache_vld_q;
    cache_color_d = cache_color_q;
    cache_idx_d   = cache_idx_q;
    out_vld_d     = out_vld_q && !out_o.ready;
    out_color_d   = out_color_q;
    out_idx_d     = out_idx_q;
    mem_req.wr_en = 1'b0;
    mem_req.rd_en = 1'b0;
    mem_req.addr  = in_i.entry_index;
    mem_req.wdata = in_i.rgb_color;

    case (state_q)
      plt_pkg::S_IDLE: begin
        if (acc) begin
          case (op)
            plt_pkg::OP_WRITE: begin
              mem_req.wr_en = in_range;
              cache_vld_d   = 1'b0;
            end
            plt_pkg::OP_LOOKUP: begin
              if (in_range) begin
                mem_req.rd_en = 1'b1;
                state_d       = plt_pkg::S_LOOK;
              end else begin
                out_vld_d   = 1'b1;
                out_color_d = '0;
                out_idx_d   = '0;
              end
            end
            plt_pkg::OP_SEARCH: begin
              if (cache_hit) begin
                out_vld_d   = 1'b1;
                out_color_d = '0;
                out_idx_d   = cache_idx_q;
              end else begin
                tgt_d   = in_i.rgb_color;
                cnt_d   = '0;
                state_d = plt_pkg::S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      plt_pkg::S_LOOK: begin
        out_vld_d   = 1'b1;
        out_color_d = rd_data;
        out_idx_d   = '0;
        state_d     = plt_pkg::S_IDLE;
      end
      plt_pkg::S_SCAN: begin
        if (issue) begin
          mem_req.rd_en = 1'b1;
          mem_req.addr  = IdxW'(cnt_q[AddrW-1:0]);
          cnt_d         = cnt_q + CntW'(1);
        end
        if (done) begin
          out_vld_d     = 1'b1;
          out_color_d   = '0;
          out_idx_d     = IdxW'(bi_d);
          cache_vld_d   = 1'b1;
          cache_color_d = tgt_q;
          cache_idx_d   = IdxW'(bi_d);
          state_d       = plt_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = plt_pkg::S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= plt_pkg::S_IDLE;
      cnt_q         <= '0;
      rd_vld_q      <= 1'b0;
      cache_vld_q   <= 1'b0;
      cache_color_q <= '0;
      cache_idx_q   <= '0;
      out_vld_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      rd_vld_q      <= issue;
      cache_vld_q   <= cache_vld_d;
      cache_color_q <= cache_color_d;
      cache_idx_q   <= cache_idx_d;
      out_vld_q     <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    tgt_q       <= tgt_d;
    rd_idx_q    <= cnt_q[AddrW-1:0];
    best_q      <= best_d;
    bi_q        <= bi_d;
    out_color_q <= out_color_d;
    out_idx_q   <= out_idx_d;
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.found_color = out_color_q;
  assign out_o.found_index = out_idx_q;

endmodule

### sv/plt_mem.sv
`timescale 1ns / 1ps
// Palette memory: one port, write or registered read, with a valid bit per entry.
// Entries never written read as their reset color. Depends on plt_pkg.
module plt_mem #(
  parameter int Entries = plt_pkg::PALETTE_ENTRIES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  plt_pkg::mem_req_t           req_i,
  output logic [plt_pkg::COLOR_W-1:0] rd_data_o
);

  localparam int AddrW = $clog2(Entries);

  logic [plt_pkg::COLOR_W-1:0] mem_q [Entries];
  logic [Entries-1:0]          vld_q;
  logic [plt_pkg::COLOR_W-1:0] rdata_q;
  logic                        ent_vld_q;
  logic [AddrW-1:0]            rd_addr_q;
  logic [AddrW-1:0]            addr;

  assign addr = req_i.addr[AddrW-1:0];

  // Store written entries and register read data
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[addr];
    end
  end

  // Mark entries as written; capture the valid bit and address of a read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      ent_vld_q <= 1'b0;
      rd_addr_q <= '0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        ent_vld_q <= vld_q[addr];
        rd_addr_q <= addr;
      end
    end
  end

  // Fall back to the reset color for entries never written
  assign rd_data_o = ent_vld_q ? rdata_q
                               : plt_pkg::reset_color(plt_pkg::IDX_W'(rd_addr_q));

endmodule

### sv/plt_dist.sv
`timescale 1ns / 1ps
// Shared distance unit: weighted squared RGB565 distance, one entry per cycle, registered.
// Depends on plt_pkg.
module plt_dist #(
  parameter int AddrW = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [plt_pkg::COLOR_W-1:0] pal_color_i,
  input  logic [plt_pkg::COLOR_W-1:0] tgt_color_i,
  input  logic [AddrW-1:0]            idx_i,
  output logic                        vld_o,
  output logic [plt_pkg::DIST_W-1:0]  dist_o,
  output logic [AddrW-1:0]            idx_o
);

  localparam int DistW = plt_pkg::DIST_W;

  logic [4:0]       pr, tr, pb, tb, dr, db;
  logic [5:0]       pg, tg, dg;
  logic [9:0]       sq_r, sq_b;
  logic [11:0]      sq_g;
  logic [DistW-1:0] dist_d;
  logic             vld_q;
  logic [DistW-1:0] dist_q;
  logic [AddrW-1:0] idx_q;

  // Split channels and take absolute differences
  assign pr = pal_color_i[15:11];
  assign pg = pal_color_i[10:5];
  assign pb = pal_color_i[4:0];
  assign tr = tgt_color_i[15:11];
  assign tg = tgt_color_i[10:5];
  assign tb = tgt_color_i[4:0];
  assign dr = (pr > tr) ? (pr - tr) : (tr - pr);
  assign dg = (pg > tg) ? (pg - tg) : (tg - pg);
  assign db = (pb > tb) ? (pb - tb) : (tb - pb);

  // Square and weight: red and blue count twice
  assign sq_r   = 10'(dr * dr);
  assign sq_g   = 12'(dg * dg);
  assign sq_b   = 10'(db * db);
  assign dist_d = DistW'({sq_r, 1'b0}) + DistW'(sq_g) + DistW'({sq_b, 1'b0});

  // Advance the beat marker
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= en_i;
    end
  end

  // Hold the distance and its entry index
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dist_q <= dist_d;
      idx_q  <= idx_i;
    end
  end

  assign vld_o  = vld_q;
  assign dist_o = dist_q;
  assign idx_o  = idx_q;

endmodule

### sv/plt_chk.sv
`timescale 1ns / 1ps
// Port-level checks of the palette unit, attached to the top level by bind.
// Depends on plt_pkg and palette_lookup_nearest_color.
module plt_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  operation_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] found_color_i,
  input logic [7:0]  found_index_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  // A result beat waits until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped before it was taken");

  // No input beat is taken over a stalled result
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (!out_valid_i || out_ready_i))
    else $error("input beat taken while a result is stalled");

  // A write or an unused operation gives no result
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && ((operation_i == plt_pkg::OP_WRITE) || (operation_i == plt_pkg::OP_NONE))
    |=> !out_valid_i)
    else $error("result beat after a write or unused operation");

  // A result carries a color or an index, never both
  a_one_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((found_color_i == '0) || (found_index_i == '0)))
    else $error("result beat carries both a color and an index");

endmodule

bind palette_lookup_nearest_color plt_chk u_plt_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .operation_i   (in_i.operation),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .found_color_i (out_o.found_color),
  .found_index_i (out_o.found_index)
);

### dv/palette_result_checker.sv
`timescale 1ns / 1ps
// Palette unit checker: mirrors the palette and the search cache, predicts each
// result beat and compares it. Depends on plt_pkg and the channels in plt_if.
module palette_result_checker #(
  parameter int PALETTE_ENTRIES = plt_pkg::PALETTE_ENTRIES
) (
  input  logic clk_i,
  input  logic rst_ni,
  plt_in_if    cmd_i,
  plt_out_if   res_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o,
  output int   cache_hits_o
);

  localparam int ENTRY_LIMIT = (PALETTE_ENTRIES > 256) ? 256 :
                               ((PALETTE_ENTRIES < 1) ? 1 : PALETTE_ENTRIES);

  typedef struct packed {
    logic [plt_pkg::COLOR_W-1:0] color;
    logic [plt_pkg::IDX_W-1:0]   index;
  } result_t;

  logic [plt_pkg::COLOR_W-1:0] pal_mirror [256];
  logic                        cache_ok;
  logic [plt_pkg::COLOR_W-1:0] cache_color;
  logic [plt_pkg::IDX_W-1:0]   cache_index;
  result_t                     due_results [$];

  int fails = 0;
  int checked = 0;
  int hits = 0;
  int outstanding = 0;

  assign fail_count_o = fails;
  assign pending_o    = outstanding;
  assign checked_o    = checked;
  assign cache_hits_o = hits;

  function automatic int unsigned sq_delta(input int unsigned a, input int unsigned b);
    int unsigned d;
    d = (a > b) ? a - b : b - a;
    return d * d;
  endfunction

  // Weighted distance over the 5/6/5 fields: red and blue count twice
  function automatic int unsigned weighted_dist(input logic [plt_pkg::COLOR_W-1:0] p,
                                                input logic [plt_pkg::COLOR_W-1:0] c);
    return 2 * sq_delta(p[15:11], c[15:11]) + sq_delta(p[10:5], c[10:5])
           + 2 * sq_delta(p[4:0], c[4:0]);
  endfunction

  // Full scan; strict less-than keeps the lowest index on a tie
  function automatic logic [plt_pkg::IDX_W-1:0] closest_entry(
    input logic [plt_pkg::COLOR_W-1:0] c);
    int unsigned best;
    int unsigned d;
    int          best_i;
    best   = weighted_dist(pal_mirror[0], c);
    best_i = 0;
    for (int i = 1; i < ENTRY_LIMIT; i++) begin
      d = weighted_dist(pal_mirror[i], c);
      if (d < best) begin
        best   = d;
        best_i = i;
      end
    end
    return plt_pkg::IDX_W'(best_i);
  endfunction

  // Gray ramp, with red and white at their fixed entries
  task automatic load_reset_palette();
    for (int i = 0; i < 256; i++) begin
      pal_mirror[i] = plt_pkg::COLOR_W'(i * plt_pkg::GRAY_STEP);
    end
    pal_mirror[plt_pkg::RED_ENTRY]   = plt_pkg::RESET_RED;
    pal_mirror[plt_pkg::WHITE_ENTRY] = plt_pkg::RESET_WHITE;
  endtask

  // Update the mirror for one command beat and queue the result it causes
  task automatic absorb_command(input plt_pkg::op_e op,
                                input logic [plt_pkg::IDX_W-1:0] idx,
                                input logic [plt_pkg::COLOR_W-1:0] col);
    result_t r;
    case (op)
      plt_pkg::OP_WRITE: begin
        if (int'(idx) < ENTRY_LIMIT) begin
          pal_mirror[idx] = col;
        end
        cache_ok = 1'b0;
      end
      plt_pkg::OP_LOOKUP: begin
        r.color = (int'(idx) < ENTRY_LIMIT) ? pal_mirror[idx] : '0;
        r.index = '0;
        due_results.push_back(r);
      end
      plt_pkg::OP_SEARCH: begin
        if (cache_ok && cache_color == col) begin
          hits++;
        end else begin
          cache_index = closest_entry(col);
          cache_color = col;
          cache_ok    = 1'b1;
        end
        r.color = '0;
        r.index = cache_index;
        due_results.push_back(r);
      end
      plt_pkg::OP_NONE: begin
      end
      default: begin
      end
    endcase
  endtask

  // Compare the result beat first: it can never belong to a command taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      load_reset_palette();
      cache_ok    = 1'b0;
      cache_color = '0;
      cache_index = '0;
      due_results.delete();
      outstanding = 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        got.color = res_i.found_color;
        got.index = res_i.found_index;
        checked++;
        if (due_results.size() == 0) begin
          fails++;
          $display("%0t: result beat with none expected: color %h index %h",
                   $time, got.color, got.index);
        end else begin
          want = due_results.pop_front();
          if (got.color !== want.color) begin
            fails++;
            $display("%0t: found_color expected %h actual %h", $time, want.color, got.color);
          end
          if (got.index !== want.index) begin
            fails++;
            $display("%0t: found_index expected %h actual %h", $time, want.index, got.index);
          end
        end
      end
      if (cmd_i.valid && cmd_i.ready) begin
        absorb_command(plt_pkg::op_e'(cmd_i.operation), cmd_i.entry_index, cmd_i.rgb_color);
      end
      outstanding = due_results.size();
    end
  end

endmodule

### dv/palette_lookup_nearest_color_tb.sv
`timescale 1ns / 1ps
// Testbench top of the palette unit: clock, reset, command and result stimulus, verdict.
// Depends on plt_pkg, plt_if, the block and palette_result_checker.
module palette_lookup_nearest_color_tb;

  localparam int ITEMS = 800;
  localparam int PHASE_ITEMS = ITEMS / 3;
  localparam int SETTLE_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1500000;

  logic clk_i;
  logic rst_ni;

  plt_in_if  in_bus ();
  plt_out_if out_bus ();

  int fail_count;
  int pending;
  int checked;
  int cache_hits;

  int snd_idle = 35;
  int rcv_idle = 72;
  int n_write = 0;
  int n_lookup = 0;
  int n_search = 0;
  int n_none = 0;
  int cycle_count = 0;

  logic [plt_pkg::COLOR_W-1:0] last_search = '0;
  logic [plt_pkg::COLOR_W-1:0] color_pool [8];

  palette_lookup_nearest_color dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  palette_result_checker result_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (in_bus),
    .res_i        (out_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .cache_hits_o (cache_hits)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Result side: drop ready at random at the current idle rate
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_bus.ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still due", cycle_count, pending);
    $display("[palette_lookup_nearest_color] ERROR");
    $finish;
  end

  // Offer one command beat after a random gap and hold it until taken
  task automatic send_beat(input plt_pkg::op_e op, input logic [plt_pkg::IDX_W-1:0] idx,
                           input logic [plt_pkg::COLOR_W-1:0] col);
    while ($urandom_range(99) < snd_idle) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.operation   <= op;
    in_bus.entry_index <= idx;
    in_bus.rgb_color   <= col;
    @(posedge clk_i);
    while (!in_bus.ready) begin
      @(posedge clk_i);
    end
    case (op)
      plt_pkg::OP_WRITE:  n_write++;
      plt_pkg::OP_LOOKUP: n_lookup++;
      plt_pkg::OP_SEARCH: n_search++;
      default:            n_none++;
    endcase
    if (op == plt_pkg::OP_SEARCH) begin
      last_search = col;
    end
  endtask

  // Hold the sender until every result is in, then switch the idle rates
  task automatic drain_then_idle(input int snd, input int rcv);
    in_bus.valid <= 1'b0;
    do begin
      @(negedge clk_i);
    end while (pending != 0);
    snd_idle = snd;
    rcv_idle = rcv;
    @(posedge clk_i);
  endtask

  // Random commands: searches most often, with repeats for cache hits and pool colors for ties
  task automatic random_phase(input int count);
    int                          done;
    int                          r;
    int                          s;
    logic [plt_pkg::COLOR_W-1:0] col;
    done = 0;
    while (done < count) begin
      r = $urandom_range(99);
      if (r < 4) begin
        send_beat(plt_pkg::OP_NONE, plt_pkg::IDX_W'($urandom), plt_pkg::COLOR_W'($urandom));
      end else begin
        done++;
        if (r < 30) begin
          col = ($urandom_range(1) == 0) ? color_pool[$urandom_range(7)]
                                         : plt_pkg::COLOR_W'($urandom);
          send_beat(plt_pkg::OP_WRITE, plt_pkg::IDX_W'($urandom), col);
        end else if (r < 52) begin
          send_beat(plt_pkg::OP_LOOKUP, plt_pkg::IDX_W'($urandom),
                    plt_pkg::COLOR_W'($urandom));
        end else begin
          s = $urandom_range(9);
          if (s < 3) begin
            col = last_search;
          end else if (s < 5) begin
            col = color_pool[$urandom_range(7)];
          end else if (s < 6) begin
            col = color_pool[$urandom_range(7)]
                  ^ plt_pkg::COLOR_W'(1 << $urandom_range(15));
          end else begin
            col = plt_pkg::COLOR_W'($urandom);
          end
          send_beat(plt_pkg::OP_SEARCH, plt_pkg::IDX_W'($urandom), col);
        end
      end
    end
  endtask

  initial begin
    rst_ni             <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.operation   <= plt_pkg::OP_NONE;
    in_bus.entry_index <= '0;
    in_bus.rgb_color   <= '0;
    color_pool[0] = 16'h0000;
    color_pool[1] = 16'hFFFF;
    for (int i = 2; i < 8; i++) begin
      color_pool[i] = plt_pkg::COLOR_W'($urandom);
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset palette, lookups at the index extremes
    send_beat(plt_pkg::OP_LOOKUP, 8'd0, 16'hFFFF);
    send_beat(plt_pkg::OP_LOOKUP, 8'd1, 16'h0000);
    send_beat(plt_pkg::OP_LOOKUP, 8'd2, 16'h0000);
    send_beat(plt_pkg::OP_LOOKUP, 8'd255, 16'h0000);
    // Searches at the color extremes, then a cache hit and an ignored beat between
    send_beat(plt_pkg::OP_SEARCH, 8'd0, 16'h0000);
    send_beat(plt_pkg::OP_SEARCH, 8'd255, 16'hFFFF);
    send_beat(plt_pkg::OP_SEARCH, 8'd0, 16'hF800);
    send_beat(plt_pkg::OP_SEARCH, 8'd0, 16'hF800);
    send_beat(plt_pkg::OP_NONE, 8'd7, 16'h1234);
    send_beat(plt_pkg::OP_SEARCH, 8'd0, 16'hF800);
    // A write must drop the cached answer
    send_beat(plt_pkg::OP_SEARCH, 8'd0, 16'h5555);
    send_beat(plt_pkg::OP_WRITE, 8'd200, 16'h5555);
    send_beat(plt_pkg::OP_SEARCH, 8'd0, 16'h5555);
    send_beat(plt_pkg::OP_WRITE, 8'd255, 16'h1234);
    send_beat(plt_pkg::OP_SEARCH, 8'd0, 16'h1234);
    send_beat(plt_pkg::OP_SEARCH, 8'd0, 16'h1234);
    // Exact ties go to the lowest index
    send_beat(plt_pkg::OP_WRITE, 8'd0, 16'h1234);
    send_beat(plt_pkg::OP_SEARCH, 8'd0, 16'h1234);
    send_beat(plt_pkg::OP_LOOKUP, 8'd0, 16'h0000);
    send_beat(plt_pkg::OP_WRITE, 8'd255, 16'hFFFF);
    send_beat(plt_pkg::OP_SEARCH, 8'd0, 16'hFFFF);
    send_beat(plt_pkg::OP_SEARCH, 8'd0, 16'h001F);
    send_beat(plt_pkg::OP_SEARCH, 8'd0, 16'h07E0);
    send_beat(plt_pkg::OP_LOOKUP, 8'd255, 16'h0000);

    random_phase(PHASE_ITEMS);
    drain_then_idle(72, 35);
    random_phase(PHASE_ITEMS);
    drain_then_idle(0, 0);
    random_phase(ITEMS - 2 * PHASE_ITEMS);
    drain_then_idle(0, 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d palette writes, %0d lookups, %0d nearest searches (%0d from cache),",
             n_write, n_lookup, n_search, cache_hits);
    $display("%0d ignored beats; %0d result beats compared, %0d mismatches, %0d never arrived",
             n_none, checked, fail_count, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("[palette_lookup_nearest_color] OK");
    end else begin
      $display("[palette_lookup_nearest_color] ERROR");
    end
    $finish;
  end

endmodule
